// ===== rtl/fdf_pkg.sv =====
// fdf_pkg: shared types and constants for the flood duplicate filter
// depends on nothing; used by every file in rtl
`default_nettype none

package fdf_pkg;

    // sizes of the trailer fields
    localparam int ADDR_W        = 32;
    localparam int ID_W          = 32;
    localparam int LEN_W         = 16;
    localparam int TTL_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    // default ring depth
    localparam int HISTORY_DEPTH_DEF = 64;

    // shortest packet that still holds the flood trailer
    localparam logic [LEN_W-1:0] TRAILER_BYTES = LEN_W'(4 * 4);

    // register reset values
    localparam logic [ADDR_W-1:0] NODE_ADDR_RST  = 32'h0000_0000;
    localparam logic              ROOT_MEMB_RST  = 1'b0;
    localparam logic [ADDR_W-1:0] BCAST_ADDR_RST = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0] ROOT_ADDR_RST  = 32'hFFFF_FFFE;

    typedef enum logic [1:0] {
        ST_NEW   = 2'd0,
        ST_DUP   = 2'd1,
        ST_SHORT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_ADDR   = 2'd0,
        REG_ROOT_MEMBER = 2'd1,
        REG_BCAST_ADDR  = 2'd2,
        REG_ROOT_ADDR   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_REPORT
    } state_t;

    // one history entry
    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ID_W-1:0]   id;
    } pair_t;

    // configuration seen by the filter logic
    typedef struct packed {
        logic [ADDR_W-1:0] node_addr;
        logic              root_member;
        logic [ADDR_W-1:0] bcast_addr;
        logic [ADDR_W-1:0] root_addr;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/fdf_hist_mem.sv =====
// fdf_hist_mem: ring memory of recently heard (source, id) pairs
// one write port, one read port with registered data; uses fdf_pkg
`default_nettype none

module fdf_hist_mem #(
    parameter int DEPTH = fdf_pkg::HISTORY_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire fdf_pkg::pair_t  wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output fdf_pkg::pair_t       rd_data
);

    fdf_pkg::pair_t mem [DEPTH];
    fdf_pkg::pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/fdf_cfg_regs.sv =====
// fdf_cfg_regs: configuration registers of the flood duplicate filter
// write channel with valid/ready; uses fdf_pkg
`default_nettype none

module fdf_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fdf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fdf_pkg::cfg_t                         cfg
);

    fdf_pkg::cfg_t cfg_reg;
    fdf_pkg::cfg_t cfg_next;

    // writes must land only while idle; the block does not enforce this, so the channel never waits
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (fdf_pkg::reg_idx_t'(cfg_index))
                fdf_pkg::REG_NODE_ADDR:   cfg_next.node_addr   = cfg_data;
                fdf_pkg::REG_ROOT_MEMBER: cfg_next.root_member = cfg_data[0];
                fdf_pkg::REG_BCAST_ADDR:  cfg_next.bcast_addr  = cfg_data;
                fdf_pkg::REG_ROOT_ADDR:   cfg_next.root_addr   = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_addr   <= fdf_pkg::NODE_ADDR_RST;
            cfg_reg.root_member <= fdf_pkg::ROOT_MEMB_RST;
            cfg_reg.bcast_addr  <= fdf_pkg::BCAST_ADDR_RST;
            cfg_reg.root_addr   <= fdf_pkg::ROOT_ADDR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/flood_duplicate_filter_top.sv =====
// flood_duplicate_filter_top: duplicate suppression and forward/deliver decision
// for received flood packets; uses fdf_pkg, fdf_cfg_regs, fdf_hist_mem
//
// channel   signals                                      direction  handshake
// command   start, busy, pkt_len, orig_src, flood_id,    in         start && !busy
//           orig_dst, ttl_in, hops_in
// result    done, status, forward, deliver, fwd_ttl,     out        done strobe, one cycle
//           fwd_hops
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    in         cfg_valid && cfg_ready
//
// a too-short beat goes straight to report; a new one scans every filled entry, then
//   inserts and reports; a duplicate hit ends the scan early; the scan reads the history
//   memory one entry a cycle through its single registered read port
// busy stays high from the accepting edge until the cycle after the done strobe
// reset clears the fill count, write slot and config; memory contents need no clearing
//   since only the first count entries are ever read
// the receiver cannot stall: each result shows for exactly one cycle under done
`default_nettype none

module flood_duplicate_filter_top #(
    parameter int HISTORY_DEPTH = fdf_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // command
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [fdf_pkg::LEN_W-1:0]         pkt_len,
    input  wire logic [fdf_pkg::ADDR_W-1:0]        orig_src,
    input  wire logic [fdf_pkg::ID_W-1:0]          flood_id,
    input  wire logic [fdf_pkg::ADDR_W-1:0]        orig_dst,
    input  wire logic [fdf_pkg::TTL_W-1:0]         ttl_in,
    input  wire logic [fdf_pkg::TTL_W-1:0]         hops_in,
    // result
    output logic                                   done,
    output logic [1:0]                             status,
    output logic                                   forward,
    output logic                                   deliver,
    output logic [fdf_pkg::TTL_W-1:0]              fwd_ttl,
    output logic [fdf_pkg::TTL_W-1:0]              fwd_hops,
    // config
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fdf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // ring address and fill count widths
    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C    = CW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(HISTORY_DEPTH - 1);
    localparam int TTL_W_L = fdf_pkg::TTL_W;
    localparam logic [TTL_W_L-1:0] TTL_MAX = '1;

    fdf_pkg::cfg_t   cfg;

    // control state
    fdf_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;    // valid entries in the ring
    logic [AW-1:0]   wpos_reg, wpos_next;      // next slot to overwrite
    logic [CW-1:0]   idx_reg, idx_next;        // next entry to read during the scan

    // latched command beat
    logic [fdf_pkg::ADDR_W-1:0] src_reg, dst_reg;
    logic [fdf_pkg::ID_W-1:0]   id_reg;
    logic [TTL_W_L-1:0]         ttl_reg, hops_reg;

    // result registers
    fdf_pkg::status_t   status_reg, status_next;
    logic               forward_reg, forward_next;
    logic               deliver_reg, deliver_next;
    logic [TTL_W_L-1:0] fwd_ttl_reg, fwd_ttl_next;
    logic [TTL_W_L-1:0] fwd_hops_reg, fwd_hops_next;

    // memory interface
    logic            mem_wr_en, mem_rd_en;
    logic [AW-1:0]   mem_rd_addr;
    fdf_pkg::pair_t  mem_wr_data, mem_rd_data;

    logic accept;
    logic too_short;
    logic hit;
    logic scan_end;
    logic fwd_ok;
    logic dlv_ok;

    fdf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fdf_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wpos_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign accept    = start && (state_reg == fdf_pkg::S_IDLE);
    assign too_short = pkt_len < fdf_pkg::TRAILER_BYTES;

    // the entry read last cycle is compared this cycle
    assign hit      = (mem_rd_data.id == id_reg) && (mem_rd_data.src == src_reg);
    // every valid entry has been issued once the read index reaches the count
    assign scan_end = (idx_reg == count_reg);

    assign fwd_ok = (ttl_reg != '0) && (src_reg != cfg.node_addr);
    assign dlv_ok = (dst_reg == cfg.bcast_addr) || (dst_reg == cfg.node_addr) ||
                    ((dst_reg == cfg.root_addr) && cfg.root_member);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    priority if (too_short)
                        state_next = fdf_pkg::S_REPORT;
                    else if (count_reg == '0)
                        state_next = fdf_pkg::S_INSERT;
                    else
                        state_next = fdf_pkg::S_SCAN;
                end
            end
            fdf_pkg::S_SCAN:
            begin
                priority if (hit)
                    state_next = fdf_pkg::S_REPORT;
                else if (scan_end)
                    state_next = fdf_pkg::S_INSERT;
            end
            fdf_pkg::S_INSERT: state_next = fdf_pkg::S_REPORT;
            fdf_pkg::S_REPORT: state_next = fdf_pkg::S_IDLE;
        endcase
    end

    // control outputs and memory strobes
    always_comb
    begin
        busy        = (state_reg != fdf_pkg::S_IDLE);
        done        = 1'b0;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            fdf_pkg::S_IDLE:
            begin
                // first read goes out on the accepting edge
                mem_rd_addr = '0;
                mem_rd_en   = accept && !too_short && (count_reg != '0);
            end
            fdf_pkg::S_SCAN:
            begin
                mem_rd_en = !hit && !scan_end;
            end
            fdf_pkg::S_INSERT:
            begin
                mem_wr_en = 1'b1;
            end
            fdf_pkg::S_REPORT:
            begin
                done = 1'b1;
            end
        endcase
    end

    assign mem_wr_data.src = src_reg;
    assign mem_wr_data.id  = id_reg;

    // ring bookkeeping, scan index and result values
    always_comb
    begin
        count_next    = count_reg;
        wpos_next     = wpos_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        forward_next  = forward_reg;
        deliver_next  = deliver_reg;
        fwd_ttl_next  = fwd_ttl_reg;
        fwd_hops_next = fwd_hops_reg;
        unique case (state_reg)
            fdf_pkg::S_IDLE:
            begin
                idx_next      = CW'(1);
                status_next   = too_short ? fdf_pkg::ST_SHORT : fdf_pkg::ST_NEW;
                forward_next  = 1'b0;
                deliver_next  = 1'b0;
                fwd_ttl_next  = '0;
                fwd_hops_next = '0;
            end
            fdf_pkg::S_SCAN:
            begin
                if (hit)
                    status_next = fdf_pkg::ST_DUP;
                else if (!scan_end)
                    idx_next = idx_reg + CW'(1);
            end
            fdf_pkg::S_INSERT:
            begin
                if (count_reg != DEPTH_C)
                    count_next = count_reg + CW'(1);
                wpos_next     = (wpos_reg == LAST_SLOT) ? '0 : wpos_reg + AW'(1);
                status_next   = fdf_pkg::ST_NEW;
                forward_next  = fwd_ok;
                deliver_next  = dlv_ok;
                fwd_ttl_next  = fwd_ok ? ttl_reg - TTL_W_L'(1) : '0;
                fwd_hops_next = !fwd_ok ? '0 :
                                (hops_reg == TTL_MAX) ? TTL_MAX : hops_reg + TTL_W_L'(1);
            end
            fdf_pkg::S_REPORT:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdf_pkg::S_IDLE;
            count_reg <= '0;
            wpos_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wpos_reg  <= wpos_next;
            idx_reg   <= idx_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg  <= orig_src;
            id_reg   <= flood_id;
            dst_reg  <= orig_dst;
            ttl_reg  <= ttl_in;
            hops_reg <= hops_in;
        end
        status_reg   <= status_next;
        forward_reg  <= forward_next;
        deliver_reg  <= deliver_next;
        fwd_ttl_reg  <= fwd_ttl_next;
        fwd_hops_reg <= fwd_hops_next;
    end

    assign status   = status_reg;
    assign forward  = forward_reg;
    assign deliver  = deliver_reg;
    assign fwd_ttl  = fwd_ttl_reg;
    assign fwd_hops = fwd_hops_reg;

    // fill count never passes the ring depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("history fill count above depth");

    // the scan never reads past the filled part of the ring
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fdf_pkg::S_SCAN) |-> (idx_reg <= count_reg) && (idx_reg != '0))
        else $error("scan index outside the filled entries");

    // a ring write always advances the write slot
    a_wpos_step: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |=> (wpos_reg != $past(wpos_reg)))
        else $error("write slot did not advance after insert");

    // only a new packet may be forwarded or delivered
    a_new_only: assert property (@(posedge clk) disable iff (!rst_n)
        done && (forward || deliver) |-> (status == fdf_pkg::ST_NEW))
        else $error("forward or deliver on a rejected packet");

    // unforwarded results carry zero ttl and hop count
    a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !forward |-> (fwd_ttl == '0) && (fwd_hops == '0))
        else $error("nonzero forward fields without forward");

endmodule

`default_nettype wire
